// ===== rtl/fuzzy_obstacle_drive_controller_defines.svh =====
`ifndef FUZZY_OBSTACLE_DRIVE_CONTROLLER_DEFINES_SVH
`define FUZZY_OBSTACLE_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FODC_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define FODC_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/fodc_pkg.sv =====
`timescale 1ns / 1ps
package fodc_pkg;

    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic [13:0] SPEED_MAX  = 14'd10000;
    localparam logic [13:0] SPAN_RESET = 14'd2375;
    localparam logic        REG_SPAN   = 1'b0;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    typedef enum logic [1:0] {
        MO_REV   = 2'd0,
        MO_RIGHT = 2'd1,
        MO_FWD   = 2'd2,
        MO_LEFT  = 2'd3
    } t_motion;

    typedef struct packed {
        logic [8:0] front_cm;
        logic [8:0] left_cm;
        logic [8:0] right_cm;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  motion;
        logic [1:0]  right_motor_dir;
        logic [1:0]  left_motor_dir;
        logic [13:0] speed_hundredths;
        logic [13:0] crisp_hundredths;
        logic        fault;
    } t_res;

    typedef struct packed {
        logic [16:0] near;
        logic [16:0] far;
    } t_mem;

    typedef struct packed {
        logic [1:0] rdir;
        logic [1:0] ldir;
    } t_dirs;

    // far membership on the 10..30 cm ramp, floor((d-10)*65536/20)
    function automatic logic [16:0] ramp_far(input logic [4:0] k);
        logic [16:0] f;
        unique case (k)
            5'd1:    f = 17'd3276;
            5'd2:    f = 17'd6553;
            5'd3:    f = 17'd9830;
            5'd4:    f = 17'd13107;
            5'd5:    f = 17'd16384;
            5'd6:    f = 17'd19660;
            5'd7:    f = 17'd22937;
            5'd8:    f = 17'd26214;
            5'd9:    f = 17'd29491;
            5'd10:   f = 17'd32768;
            5'd11:   f = 17'd36044;
            5'd12:   f = 17'd39321;
            5'd13:   f = 17'd42598;
            5'd14:   f = 17'd45875;
            5'd15:   f = 17'd49152;
            5'd16:   f = 17'd52428;
            5'd17:   f = 17'd55705;
            5'd18:   f = 17'd58982;
            5'd19:   f = 17'd62259;
            5'd20:   f = 17'd65536;
            default: f = Q_ONE;
        endcase
        return f;
    endfunction

    function automatic t_mem member(input logic [8:0] d);
        t_mem m;
        logic [8:0] k;
        k = d - 9'd10;
        priority if (d >= 9'd1 && d <= 9'd10) begin
            m.near = Q_ONE;
            m.far  = 17'd0;
        end else if (d >= 9'd11 && d <= 9'd30) begin
            m.far  = ramp_far(k[4:0]);
            m.near = Q_ONE - m.far;
        end else begin
            m.far  = Q_ONE;
            m.near = 17'd0;
        end
        return m;
    endfunction

    function automatic logic [16:0] min3(input logic [16:0] a, input logic [16:0] b,
                                         input logic [16:0] c);
        logic [16:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic t_dirs dirs_of(input t_motion mo);
        t_dirs d;
        unique case (mo)
            MO_REV:   begin d.rdir = DIR_BACK; d.ldir = DIR_BACK; end
            MO_RIGHT: begin d.rdir = DIR_BACK; d.ldir = DIR_FWD;  end
            MO_FWD:   begin d.rdir = DIR_FWD;  d.ldir = DIR_FWD;  end
            MO_LEFT:  begin d.rdir = DIR_FWD;  d.ldir = DIR_BACK; end
            default:  begin d.rdir = DIR_STOP; d.ldir = DIR_STOP; end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/fodc_fuzz.sv =====
`timescale 1ns / 1ps
module fodc_fuzz (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  fodc_pkg::t_cmd     i_cmd,
    output logic               o_vld,
    output logic [34:0]        o_sum_l,
    output logic [34:0]        o_sum_r,
    output logic [16:0]        o_fwd,
    output logic [16:0]        o_rev
);
    import fodc_pkg::*;

    logic [3:0]  r_v;
    t_mem        r_mf, r_ml, r_mr;
    logic [16:0] r_fwd, r_rev, r_r2, r_r3, r_r4, r_r5, r_r6, r_r7;
    logic [16:0] r_fwd3, r_rev3;
    logic [33:0] r_q2, r_q3, r_q4, r_q5, r_q6, r_q7;
    logic [34:0] r_sl, r_sr;
    logic [16:0] r_fwd4, r_rev4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // memberships
        r_mf <= member(i_cmd.front_cm);
        r_ml <= member(i_cmd.left_cm);
        r_mr <= member(i_cmd.right_cm);
        // min rules
        r_fwd <= min3(r_ml.far,  r_mf.far,  r_mr.far);
        r_r2  <= min3(r_ml.far,  r_mf.far,  r_mr.near);
        r_r3  <= min3(r_ml.far,  r_mf.near, r_mr.far);
        r_r4  <= min3(r_ml.far,  r_mf.near, r_mr.near);
        r_r5  <= min3(r_ml.near, r_mf.far,  r_mr.far);
        r_r6  <= min3(r_ml.near, r_mf.far,  r_mr.near);
        r_r7  <= min3(r_ml.near, r_mf.near, r_mr.far);
        r_rev <= min3(r_ml.near, r_mf.near, r_mr.near);
        // squares
        r_q2   <= r_r2 * r_r2;
        r_q3   <= r_r3 * r_r3;
        r_q4   <= r_r4 * r_r4;
        r_q5   <= r_r5 * r_r5;
        r_q6   <= r_r6 * r_r6;
        r_q7   <= r_r7 * r_r7;
        r_fwd3 <= r_fwd;
        r_rev3 <= r_rev;
        // sums of squares
        r_sl   <= 35'(r_q2) + 35'(r_q4);
        r_sr   <= 35'(r_q3) + 35'(r_q5) + 35'(r_q6) + 35'(r_q7);
        r_fwd4 <= r_fwd3;
        r_rev4 <= r_rev3;
    end

    assign o_vld   = r_v[3];
    assign o_sum_l = r_sl;
    assign o_sum_r = r_sr;
    assign o_fwd   = r_fwd4;
    assign o_rev   = r_rev4;
endmodule

// ===== rtl/fodc_sqrt.sv =====
`timescale 1ns / 1ps
module fodc_sqrt #(
    parameter int NW = 35,
    parameter int RW = 18,
    parameter int SW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_val,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    localparam int TW = 2 * RW + 1;

    logic [RW:0]   r_v;
    logic [NW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [SW-1:0] r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[RW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_val;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    // one root bit per stage, most significant first
    for (genvar j = 1; j <= RW; j++) begin : g_stage
        localparam int B = RW - j;
        logic [TW-1:0] w_term;
        logic          w_ge;
        assign w_term = (TW'(r_root[j-1]) << (B + 1)) + (TW'(1) << (2 * B));
        assign w_ge   = TW'(r_rem[j-1]) >= w_term;
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_ge ? r_rem[j-1] - w_term[NW-1:0] : r_rem[j-1];
            r_root[j] <= w_ge ? r_root[j-1] | (RW'(1) << B) : r_root[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_vld  = r_v[RW];
    assign o_root = r_root[RW];
    assign o_side = r_side[RW];
endmodule

// ===== rtl/fodc_div.sv =====
`timescale 1ns / 1ps
module fodc_div #(
    parameter int NW = 46,
    parameter int DW = 34,
    parameter int QW = 14,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic          o_sat,
    output logic [SW-1:0] o_side
);
    logic [QW:0]   r_v;
    logic [NW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_quo  [0:QW];
    logic          r_sat  [0:QW];
    logic [SW-1:0] r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QW-1:0], i_vld};
        end
    end

    // quotient too large for QW bits
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
        r_sat[0]  <= (i_num >> QW) >= NW'(i_den);
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        localparam int B = QW - j;
        logic w_ge;
        assign w_ge = (r_rem[j-1] >> B) >= NW'(r_den[j-1]);
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_ge ? r_rem[j-1] - (NW'(r_den[j-1]) << B) : r_rem[j-1];
            r_quo[j]  <= w_ge ? r_quo[j-1] | (QW'(1) << B) : r_quo[j-1];
            r_den[j]  <= r_den[j-1];
            r_sat[j]  <= r_sat[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_vld  = r_v[QW];
    assign o_quo  = r_quo[QW];
    assign o_sat  = r_sat[QW];
    assign o_side = r_side[QW];
endmodule

// ===== rtl/fodc_zone.sv =====
`timescale 1ns / 1ps
module fodc_zone (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [16:0] i_fwd,
    input  logic [16:0] i_rev,
    input  logic [17:0] i_lft,
    input  logic [17:0] i_rgt,
    input  logic [13:0] i_span,
    output logic        o_vld,
    output logic [45:0] o_num_spd,
    output logic [33:0] o_den_spd,
    output logic [33:0] o_num_crisp,
    output logic [20:0] o_den_crisp,
    output logic [1:0]  o_motion,
    output logic        o_fault
);
    import fodc_pkg::*;

    logic [4:0]  r_v;
    // stage 1
    logic [19:0] r_den1;
    logic [28:0] r_x1;
    // stage 2
    logic [19:0] r_den2;
    logic [28:0] r_x2;
    logic [26:0] r_h2;
    // stage 3
    logic [19:0] r_den3;
    logic [28:0] r_x3;
    logic [26:0] r_h3;
    logic [2:0]  r_s3;
    logic        r_flt3;
    // stage 4
    logic [19:0] r_den4;
    logic [28:0] r_x4;
    logic [28:0] r_off4;
    logic [2:0]  r_s4;
    logic        r_flt4;
    // stage 5
    logic [45:0] r_nspd;
    logic [33:0] r_dspd;
    logic [33:0] r_ncr;
    logic [20:0] r_dcr;
    logic [1:0]  r_mo5;
    logic        r_flt5;

    logic [13:0] w_span;
    logic [28:0] w_xm1;
    logic [2:0]  w_s;

    assign w_span = (i_span == 14'd0) ? 14'd1 : i_span;
    assign w_xm1  = r_x2 - 29'd1;

    // zone index: how many multiples of 100*den lie strictly below x
    always_comb begin
        w_s = 3'd0;
        if (r_x2 != 29'd0) begin
            for (int k = 1; k <= 7; k++) begin
                if (30'(w_xm1) >= 30'(r_h2) * 30'(k)) w_s = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_den1 <= 20'(i_fwd) + 20'(i_rgt) + 20'(i_lft) + 20'(i_rev);
        r_x1   <= 29'(4) * (29'(125) * 29'(i_fwd) + 29'(75) * 29'(i_rgt)
                          + 29'(175) * 29'(i_lft) + 29'(25) * 29'(i_rev));

        r_den2 <= r_den1;
        r_x2   <= r_x1;
        r_h2   <= 27'(r_den1) * 27'(100);

        r_den3 <= r_den2;
        r_x3   <= r_x2;
        r_h3   <= r_h2;
        r_s3   <= w_s;
        r_flt3 <= (r_den2 == 20'd0) || (30'(r_x2) > 30'(r_h2) * 30'(8));

        r_den4 <= r_den3;
        r_x4   <= r_x3;
        r_off4 <= r_x3 - 29'(30'(r_h3) * 30'(r_s3));
        r_s4   <= r_s3;
        r_flt4 <= r_flt3;

        r_nspd <= 46'(r_off4) * 46'(125000);
        r_dspd <= 34'(r_den4) * 34'(w_span);
        r_ncr  <= 34'(r_x4) * 34'(25);
        r_dcr  <= {1'b0, r_den4} << 1;
        r_mo5  <= r_s4[2:1];
        r_flt5 <= r_flt4;
    end

    assign o_vld       = r_v[4];
    assign o_num_spd   = r_nspd;
    assign o_den_spd   = r_dspd;
    assign o_num_crisp = r_ncr;
    assign o_den_crisp = r_dcr;
    assign o_motion    = r_mo5;
    assign o_fault     = r_flt5;
endmodule

// ===== rtl/fuzzy_obstacle_drive_controller.sv =====
`timescale 1ns / 1ps
// Pipeline from start to o_valid: fuzzify, square roots, centroid, dividers, output register;
//   the root and divider depths follow from the 18-bit root and 14-bit quotient pipelines.
// Throughput: one word per cycle; o_busy is always low and the receiver cannot stall.
// Reset (i_rst_n low, synchronous): pipeline valid bits clear, speed_span returns to 2375.
`include "fuzzy_obstacle_drive_controller_defines.svh"
module fuzzy_obstacle_drive_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // command channel
    input  logic           i_start,
    input  fodc_pkg::t_cmd i_cmd,
    output logic           o_busy,
    output logic           o_valid,
    output fodc_pkg::t_res o_res,
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import fodc_pkg::*;

    logic [13:0] r_span;
    logic        w_wr;

    // fuzzify / rules
    logic        w_fz_vld;
    logic [34:0] w_sum_l, w_sum_r;
    logic [16:0] w_fwd, w_rev;

    // roots
    logic        w_sl_vld, w_sr_vld;
    logic [17:0] w_lft, w_rgt;
    logic [16:0] w_fwd_q, w_rev_q;

    // centroid
    logic        w_zn_vld;
    logic [45:0] w_num_spd;
    logic [33:0] w_den_spd;
    logic [33:0] w_num_cr;
    logic [20:0] w_den_cr;
    logic [1:0]  w_motion;
    logic        w_fault;

    // dividers
    logic        w_ds_vld, w_dc_vld;
    logic [13:0] w_q_spd, w_q_cr;
    logic        w_sat_spd, w_sat_cr;
    logic [1:0]  w_mo_d;
    logic        w_flt_d;

    logic        r_valid;
    t_res        r_res;
    t_res        w_res;
    t_dirs       w_dirs;

    // -------- register port --------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SPAN) ? {18'd0, r_span} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= SPAN_RESET;
        end else if (w_wr && paddr[2] == REG_SPAN) begin
            r_span <= pwdata[13:0];
        end
    end

    // fully pipelined, never busy
    assign o_busy = 1'b0;

    fodc_fuzz u_fuzz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_cmd   (i_cmd),
        .o_vld   (w_fz_vld),
        .o_sum_l (w_sum_l),
        .o_sum_r (w_sum_r),
        .o_fwd   (w_fwd),
        .o_rev   (w_rev)
    );

    // left strength, carries forward strength alongside
    fodc_sqrt #(.NW(35), .RW(18), .SW(17)) u_sqrt_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fz_vld),
        .i_val   (w_sum_l),
        .i_side  (w_fwd),
        .o_vld   (w_sl_vld),
        .o_root  (w_lft),
        .o_side  (w_fwd_q)
    );

    // right strength, carries reverse strength alongside
    fodc_sqrt #(.NW(35), .RW(18), .SW(17)) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fz_vld),
        .i_val   (w_sum_r),
        .i_side  (w_rev),
        .o_vld   (w_sr_vld),
        .o_root  (w_rgt),
        .o_side  (w_rev_q)
    );

    fodc_zone u_zone (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_sl_vld && w_sr_vld),
        .i_fwd       (w_fwd_q),
        .i_rev       (w_rev_q),
        .i_lft       (w_lft),
        .i_rgt       (w_rgt),
        .i_span      (r_span),
        .o_vld       (w_zn_vld),
        .o_num_spd   (w_num_spd),
        .o_den_spd   (w_den_spd),
        .o_num_crisp (w_num_cr),
        .o_den_crisp (w_den_cr),
        .o_motion    (w_motion),
        .o_fault     (w_fault)
    );

    // speed = off*125000 / (den*span)
    fodc_div #(.NW(46), .DW(34), .QW(14), .SW(2)) u_div_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_zn_vld),
        .i_num   (w_num_spd),
        .i_den   (w_den_spd),
        .i_side  (w_motion),
        .o_vld   (w_ds_vld),
        .o_quo   (w_q_spd),
        .o_sat   (w_sat_spd),
        .o_side  (w_mo_d)
    );

    // crisp = 25*x / (2*den)
    fodc_div #(.NW(34), .DW(21), .QW(14), .SW(1)) u_div_crisp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_zn_vld),
        .i_num   (w_num_cr),
        .i_den   (w_den_cr),
        .i_side  (w_fault),
        .o_vld   (w_dc_vld),
        .o_quo   (w_q_cr),
        .o_sat   (w_sat_cr),
        .o_side  (w_flt_d)
    );

    // -------- result formatting: saturate, zero everything on fault --------
    assign w_dirs = dirs_of(t_motion'(w_mo_d));

    always_comb begin
        w_res = '0;
        w_res.fault = w_flt_d;
        if (!w_flt_d) begin
            w_res.motion           = w_mo_d;
            w_res.right_motor_dir  = w_dirs.rdir;
            w_res.left_motor_dir   = w_dirs.ldir;
            w_res.speed_hundredths = (w_sat_spd || w_q_spd > SPEED_MAX) ? SPEED_MAX
                                                                        : w_q_spd;
            w_res.crisp_hundredths = (w_sat_cr || w_q_cr > SPEED_MAX) ? SPEED_MAX
                                                                      : w_q_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ds_vld && w_dc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= w_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // -------- checks --------
    `FODC_AST_IMP(a_fault_zero, o_valid && o_res.fault,
        o_res.motion == 2'd0 && o_res.speed_hundredths == 14'd0 &&
        o_res.crisp_hundredths == 14'd0 && o_res.right_motor_dir == DIR_STOP)
    `FODC_AST_IMP(a_sat_range, o_valid && !o_res.fault,
        o_res.speed_hundredths <= SPEED_MAX && o_res.crisp_hundredths <= SPEED_MAX)
    `FODC_AST_IMP(a_dirs_run, o_valid && !o_res.fault,
        o_res.right_motor_dir != DIR_STOP && o_res.left_motor_dir != DIR_STOP)
    `FODC_AST_IMP(a_lanes_align, w_ds_vld || w_dc_vld, w_ds_vld && w_dc_vld)
    `FODC_AST_NXT(a_span_write, w_wr && paddr[2] == REG_SPAN,
        r_span == $past(pwdata[13:0]))
endmodule
